>>> hw/rtl/ofs_pkg.sv
`default_nettype none

package ofs_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MESSAGE_WORD   = 3'd0,
		REG_TICKS_PER_BIT  = 3'd1,
		REG_PREAMBLE_BYTE  = 3'd2,
		REG_PREAMBLE_COUNT = 3'd3,
		REG_START_BYTE     = 3'd4,
		REG_END_BYTE       = 3'd5
	} cfg_index_t;

	localparam logic [63:0] RST_MESSAGE_WORD   = 64'h0;
	localparam logic [15:0] RST_TICKS_PER_BIT  = 16'd13;
	localparam logic [7:0]  RST_PREAMBLE_BYTE  = 8'hAA;
	localparam logic [3:0]  RST_PREAMBLE_COUNT = 4'd2;
	localparam logic [7:0]  RST_START_BYTE     = 8'hAA;
	localparam logic [7:0]  RST_END_BYTE       = 8'h55;

	typedef struct packed {
		logic [63:0] message_word;
		logic [15:0] ticks_per_bit;
		logic [7:0]  preamble_byte;
		logic [3:0]  preamble_count;
		logic [7:0]  start_byte;
		logic [7:0]  end_byte;
	} cfg_t;

	typedef struct packed {
		logic       line_level;
		logic       bit_start;
		logic       frame_end;
		logic [7:0] frame_position;
	} res_t;

endpackage

`default_nettype wire

>>> hw/rtl/ook_frame_serializer.sv
// pipeline: an accepted request is held in the input register, and its result is offered from the result register
// throughput: one request per cycle while the output is not stalled; the tick counter and bit position
// update in a single pass from the input register to the result register
// reset: asynchronous, active low; clears the frame position, the held line
// level and the valid flags of both pipeline registers, and loads the
// register reset values
`default_nettype none

module ook_frame_serializer #(
	parameter int unsigned MESSAGE_BYTES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [ofs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ofs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             enable,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             line_level,
	output logic                             bit_start,
	output logic                             frame_end,
	output logic [7:0]                       frame_position
);
	import ofs_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t res_s2;
	logic valid_s1;
	logic enable_s1;
	logic valid_s2;
	logic advance;
	logic in_take;

	ofs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ofs_bit_engine #(
		.MESSAGE_BYTES (MESSAGE_BYTES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.enable (enable_s1),
		.res    (res)
	);

	// the input register moves on when the result register is free or emptying
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			enable_s1 <= enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign line_level     = res_s2.line_level;
	assign bit_start      = res_s2.bit_start;
	assign frame_end      = res_s2.frame_end;
	assign frame_position = res_s2.frame_position;

endmodule

`default_nettype wire

>>> hw/rtl/ofs_cfg_regs.sv
`default_nettype none

module ofs_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [ofs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ofs_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ofs_pkg::cfg_t                      cfg
);
	import ofs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.message_word   <= RST_MESSAGE_WORD;
			cfg_q.ticks_per_bit  <= RST_TICKS_PER_BIT;
			cfg_q.preamble_byte  <= RST_PREAMBLE_BYTE;
			cfg_q.preamble_count <= RST_PREAMBLE_COUNT;
			cfg_q.start_byte     <= RST_START_BYTE;
			cfg_q.end_byte       <= RST_END_BYTE;
		end else if (cfg_write) begin
			// indexes past the register list are dropped
			unique case (cfg_index_t'(cfg_index))
				REG_MESSAGE_WORD:   cfg_q.message_word   <= cfg_data;
				REG_TICKS_PER_BIT:  cfg_q.ticks_per_bit  <= cfg_data[15:0];
				REG_PREAMBLE_BYTE:  cfg_q.preamble_byte  <= cfg_data[7:0];
				REG_PREAMBLE_COUNT: cfg_q.preamble_count <= cfg_data[3:0];
				REG_START_BYTE:     cfg_q.start_byte     <= cfg_data[7:0];
				REG_END_BYTE:       cfg_q.end_byte       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/ofs_bit_engine.sv
`default_nettype none

module ofs_bit_engine #(
	parameter int unsigned MESSAGE_BYTES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ofs_pkg::cfg_t  cfg,
	input  logic           step,
	input  logic           enable,
	output ofs_pkg::res_t  res
);
	import ofs_pkg::*;

	localparam logic [4:0] MSG_BYTES = 5'(MESSAGE_BYTES);

	logic [15:0] tick_q;
	logic [2:0]  bit_q;
	logic [4:0]  byte_q;
	logic        level_q;

	logic [4:0]  last_byte;
	logic        wrap;
	logic [15:0] tick_e;
	logic [2:0]  bit_e;
	logic [4:0]  byte_e;
	logic [15:0] limit;
	logic        first_tick;
	logic [4:0]  msg_off;
	logic [7:0]  cur_byte;
	logic        level_n;
	logic [15:0] tick_inc;
	logic        bit_done;
	logic        frame_done;
	logic [15:0] tick_n;
	logic [2:0]  bit_n;
	logic [4:0]  byte_n;

	always_comb begin
		last_byte = {1'b0, cfg.preamble_count} + 5'd1 + MSG_BYTES;
		// position left past the end byte after a smaller preamble count
		wrap   = byte_q > last_byte;
		tick_e = wrap ? 16'd0 : tick_q;
		bit_e  = wrap ? 3'd0 : bit_q;
		byte_e = wrap ? 5'd0 : byte_q;
		limit  = (cfg.ticks_per_bit == 16'd0) ? 16'd1 : cfg.ticks_per_bit;

		msg_off = byte_e - {1'b0, cfg.preamble_count} - 5'd1;
		priority if (byte_e < {1'b0, cfg.preamble_count}) begin
			cur_byte = cfg.preamble_byte;
		end else if (byte_e == {1'b0, cfg.preamble_count}) begin
			cur_byte = cfg.start_byte;
		end else if (byte_e < last_byte) begin
			cur_byte = cfg.message_word[{msg_off[2:0], 3'b000} +: 8];
		end else begin
			cur_byte = cfg.end_byte;
		end

		first_tick = tick_e == 16'd0;
		level_n    = first_tick ? cur_byte[bit_e] : level_q;

		tick_inc = tick_e + 16'd1;
		bit_done = (tick_inc >= limit) || (tick_inc == 16'd0);

		tick_n     = bit_done ? 16'd0 : tick_inc;
		bit_n      = bit_e;
		byte_n     = byte_e;
		frame_done = 1'b0;
		if (bit_done) begin
			bit_n = bit_e + 3'd1;
			if (bit_e == 3'd7) begin
				if (byte_e >= last_byte) begin
					byte_n     = 5'd0;
					frame_done = 1'b1;
				end else begin
					byte_n = byte_e + 5'd1;
				end
			end
		end

		if (enable) begin
			res.line_level     = level_n;
			res.bit_start      = first_tick;
			res.frame_end      = frame_done;
			res.frame_position = {byte_e, bit_e};
		end else begin
			res.line_level     = level_q;
			res.bit_start      = 1'b0;
			res.frame_end      = 1'b0;
			res.frame_position = {byte_q, bit_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			level_q <= 1'b0;
		end else if (step && enable) begin
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			level_q <= level_n;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ofs_checker.sv
`default_nettype none

module ofs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       line_level,
	input logic       bit_start,
	input logic       frame_end,
	input logic [7:0] frame_position
);

	// the frame closes on the last bit of a byte
	a_frame_end_bit7: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> (frame_position[2:0] == 3'd7))
		else $error("frame end away from the last bit of a byte");

	// longest frame is 25 bytes
	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_position <= 8'd199))
		else $error("frame position beyond the longest frame");

	// an empty result register never holds back a request
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while the result register is empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(line_level)
			&& $stable(bit_start) && $stable(frame_end) && $stable(frame_position)))
		else $error("stalled result changed");

endmodule

bind ook_frame_serializer ofs_checker u_ofs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.line_level     (line_level),
	.bit_start      (bit_start),
	.frame_end      (frame_end),
	.frame_position (frame_position)
);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import ofs_pkg::*;

	localparam int unsigned MESSAGE_BYTES = 8;
	localparam int unsigned RANDOM_ITEMS  = 1100;
	localparam int unsigned MAX_REPORTS   = 100;

	// tracks the frame position, the held level and the register values,
	// and holds the results the line should produce, oldest first
	class frame_line_tracker;
		logic [63:0] message_word;
		logic [15:0] ticks_per_bit;
		logic [7:0]  preamble_byte;
		logic [3:0]  preamble_count;
		logic [7:0]  start_byte;
		logic [7:0]  end_byte;

		logic [15:0] tick_count;
		logic [2:0]  bit_pos;
		logic [4:0]  byte_pos;
		logic        held_level;

		res_t        expected_lines[$];
		int unsigned failures;

		function void load_reset_values();
			message_word   = RST_MESSAGE_WORD;
			ticks_per_bit  = RST_TICKS_PER_BIT;
			preamble_byte  = RST_PREAMBLE_BYTE;
			preamble_count = RST_PREAMBLE_COUNT;
			start_byte     = RST_START_BYTE;
			end_byte       = RST_END_BYTE;
			tick_count     = '0;
			bit_pos        = '0;
			byte_pos       = '0;
			held_level     = 1'b0;
			expected_lines.delete();
			failures       = 0;
		endfunction

		function void configure(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
			case (idx)
				REG_MESSAGE_WORD:   message_word   = data;
				REG_TICKS_PER_BIT:  ticks_per_bit  = data[15:0];
				REG_PREAMBLE_BYTE:  preamble_byte  = data[7:0];
				REG_PREAMBLE_COUNT: preamble_count = data[3:0];
				REG_START_BYTE:     start_byte     = data[7:0];
				REG_END_BYTE:       end_byte       = data[7:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] frame_byte(logic [4:0] pos, logic [4:0] last);
			logic [4:0] k;
			if (pos < 5'(preamble_count))
				return preamble_byte;
			if (pos == 5'(preamble_count))
				return start_byte;
			if (pos < last) begin
				k = (pos - 5'(preamble_count) - 5'd1) & 5'd7;
				return message_word[8*k +: 8];
			end
			return end_byte;
		endfunction

		function void note_tick(logic en);
			res_t        r;
			logic [4:0]  last;
			logic [15:0] limit;
			logic [7:0]  cur;
			r = '0;
			if (!en) begin
				r.line_level     = held_level;
				r.frame_position = {byte_pos, bit_pos};
			end else begin
				last = 5'(preamble_count) + 5'd1 + 5'(MESSAGE_BYTES);
				// preamble shortened while the position sat beyond the new end byte
				if (byte_pos > last) begin
					byte_pos   = '0;
					bit_pos    = '0;
					tick_count = '0;
				end
				limit = (ticks_per_bit == 16'd0) ? 16'd1 : ticks_per_bit;
				if (tick_count == 16'd0) begin
					cur        = frame_byte(byte_pos, last);
					held_level = cur[bit_pos];
					r.bit_start = 1'b1;
				end
				r.frame_position = {byte_pos, bit_pos};
				tick_count = tick_count + 16'd1;
				if (tick_count >= limit || tick_count == 16'd0) begin
					tick_count = '0;
					if (bit_pos == 3'd7) begin
						bit_pos = '0;
						if (byte_pos >= last) begin
							byte_pos    = '0;
							r.frame_end = 1'b1;
						end else begin
							byte_pos = byte_pos + 5'd1;
						end
					end else begin
						bit_pos = bit_pos + 3'd1;
					end
				end
				r.line_level = held_level;
			end
			expected_lines.push_back(r);
		endfunction

		function void report_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
			if (exp_v !== act_v) begin
				if (failures < MAX_REPORTS)
					$display("%0t mismatch %s: expected %0d, actual %0d",
						$time, name, exp_v, act_v);
				failures++;
			end
		endfunction

		function void check_line(res_t got);
			res_t e;
			if (expected_lines.size() == 0) begin
				if (failures < MAX_REPORTS)
					$display("%0t unexpected result: expected none, actual %h", $time, got);
				failures++;
				return;
			end
			e = expected_lines.pop_front();
			report_field("line_level", 8'(e.line_level), 8'(got.line_level));
			report_field("bit_start", 8'(e.bit_start), 8'(got.bit_start));
			report_field("frame_end", 8'(e.frame_end), 8'(got.frame_end));
			report_field("frame_position", e.frame_position, got.frame_position);
		endfunction

		function int unsigned pending();
			return expected_lines.size();
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic                   enable    = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   line_level;
	logic                   bit_start;
	logic                   frame_end;
	logic [7:0]             frame_position;

	frame_line_tracker line_sb;
	int unsigned       src_idle_pct   = 0;
	int unsigned       sink_stall_pct = 0;
	int unsigned       sent_total     = 0;

	ook_frame_serializer #(
		.MESSAGE_BYTES(MESSAGE_BYTES)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.enable         (enable),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.line_level     (line_level),
		.bit_start      (bit_start),
		.frame_end      (frame_end),
		.frame_position (frame_position)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// request noted before the result so a same-edge result still finds it
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				line_sb.note_tick(enable);
			if (out_valid && !out_stall)
				line_sb.check_line('{line_level, bit_start, frame_end, frame_position});
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		line_sb.configure(idx, data);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_tick(input logic en);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		enable   <= en;
		do @(posedge clk); while (in_stall);
		sent_total++;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (line_sb.pending() != 0);
	endtask

	task automatic send_ticks(input int unsigned n, input int unsigned enable_pct);
		repeat (n) send_tick($urandom_range(99) < enable_pct);
		in_valid <= 1'b0;
		wait_drained();
	endtask

	task automatic send_pattern(input logic [31:0] pattern, input int unsigned n);
		for (int i = 0; i < n; i++)
			send_tick(pattern[i]);
		in_valid <= 1'b0;
		wait_drained();
	endtask

	task automatic randomise_config();
		int unsigned roll;
		logic [15:0] bit_time;
		if ($urandom_range(3) == 0)
			write_reg(REG_MESSAGE_WORD, {$urandom, $urandom});
		if ($urandom_range(1)) begin
			roll = $urandom_range(99);
			if (roll < 70)
				bit_time = 16'($urandom_range(3, 1));
			else if (roll < 90)
				bit_time = 16'($urandom_range(20, 4));
			else
				bit_time = 16'($urandom_range(65535, 21));
			write_reg(REG_TICKS_PER_BIT, 64'(bit_time));
		end
		if ($urandom_range(3) == 0)
			write_reg(REG_PREAMBLE_BYTE, 64'($urandom));
		if ($urandom_range(1))
			write_reg(REG_PREAMBLE_COUNT, 64'($urandom));
		if ($urandom_range(3) == 0)
			write_reg(REG_START_BYTE, 64'($urandom));
		if ($urandom_range(3) == 0)
			write_reg(REG_END_BYTE, 64'($urandom));
		if ($urandom_range(15) == 0)
			write_reg(CFG_INDEX_W'(REG_END_BYTE) + 3'd1 + 3'($urandom_range(1)),
				{$urandom, $urandom});
	endtask

	initial begin : stimulus
		int unsigned random_start;
		int unsigned done;
		line_sb = new;
		line_sb.load_reset_values();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, then disabled ticks holding the line
		src_idle_pct   = 15;
		sink_stall_pct = 75;
		send_pattern(32'b00111, 5);

		// zero bit time behaves as one tick, extreme values elsewhere
		write_reg(REG_MESSAGE_WORD, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_TICKS_PER_BIT, 64'd0);
		write_reg(REG_PREAMBLE_BYTE, 64'h00);
		write_reg(REG_PREAMBLE_COUNT, 64'd0);
		write_reg(REG_START_BYTE, 64'hFF);
		write_reg(REG_END_BYTE, 64'h00);
		write_reg(CFG_INDEX_W'(REG_END_BYTE) + 3'd1, {$urandom, $urandom});
		send_pattern(32'b111111, 6);

		// longest bit time, then shortened below the count mid-bit
		write_reg(REG_MESSAGE_WORD, 64'h0);
		write_reg(REG_TICKS_PER_BIT, 64'd65535);
		write_reg(REG_PREAMBLE_BYTE, 64'hFF);
		write_reg(REG_PREAMBLE_COUNT, 64'd15);
		write_reg(REG_START_BYTE, 64'h00);
		write_reg(REG_END_BYTE, 64'hFF);
		send_pattern(32'b01111, 5);
		write_reg(REG_TICKS_PER_BIT, 64'd3);
		send_pattern(32'b111, 3);

		// run deep into a long frame, then cut the preamble so the position
		// lies past the end byte
		write_reg(REG_TICKS_PER_BIT, 64'd1);
		write_reg(REG_MESSAGE_WORD, {$urandom, $urandom});
		random_start = sent_total;
		send_ticks(140, 95);
		write_reg(REG_PREAMBLE_COUNT, 64'($urandom_range(3)));

		done = 0;
		while (done < RANDOM_ITEMS) begin
			if (done < RANDOM_ITEMS / 3) begin
				src_idle_pct   = 15;
				sink_stall_pct = 75;
			end else if (done < 2 * RANDOM_ITEMS / 3) begin
				src_idle_pct   = 75;
				sink_stall_pct = 15;
			end else begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end
			send_ticks($urandom_range(160, 40), ($urandom_range(9) == 0) ? 50 : 92);
			randomise_config();
			done = sent_total - random_start;
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (line_sb.failures == 0 && line_sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
